// ===== sv/wavetable_voice_with_envelope_top_macros.svh =====
// assertion macros shared by the voice checker
`ifndef WAVETABLE_VOICE_WITH_ENVELOPE_TOP_MACROS_SVH
`define WAVETABLE_VOICE_WITH_ENVELOPE_TOP_MACROS_SVH

// consequent checked in the cycle after the antecedent
`define WTV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// consequent checked in the same cycle as the antecedent
`define WTV_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== sv/wtv_pkg.sv =====
// shared types and codes for the wavetable voice
`timescale 1ns / 1ps

package wtv_pkg;

    // request codes carried by req_type
    localparam logic [2:0] REQ_TICK     = 3'd0;
    localparam logic [2:0] REQ_NOTE_ON  = 3'd1;
    localparam logic [2:0] REQ_NOTE_OFF = 3'd2;
    localparam logic [2:0] REQ_WAVE_WR  = 3'd3;
    localparam logic [2:0] REQ_TUNE_WR  = 3'd4;

    // configuration register indexes
    localparam logic [2:0] CFG_WAVE_SELECT = 3'd0;
    localparam logic [2:0] CFG_GAIN        = 3'd1;
    localparam logic [2:0] CFG_ATTACK      = 3'd2;
    localparam logic [2:0] CFG_RELEASE     = 3'd3;
    localparam logic [2:0] CFG_SUSTAIN     = 3'd4;

    // envelope states
    localparam logic [2:0] ENV_IDLE    = 3'd0;
    localparam logic [2:0] ENV_ATTACK  = 3'd1;
    localparam logic [2:0] ENV_DECAY   = 3'd2;
    localparam logic [2:0] ENV_SUSTAIN = 3'd3;
    localparam logic [2:0] ENV_RELEASE = 3'd4;

    // fixed widths
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int LEVEL_W     = 32;
    localparam int LEN_W       = 24;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 32'hFFFF_FFFF;

    // divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== sv/wtv_div.sv =====
// restoring divider, one quotient bit per cycle, for envelope rates
`timescale 1ns / 1ps

module wtv_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [wtv_pkg::LEVEL_W-1:0]         dividend,
    input  logic [wtv_pkg::LEN_W-1:0]           divisor,
    output wtv_pkg::div_stat_t                  stat,
    output logic [wtv_pkg::LEVEL_W-1:0]         quotient
);

    localparam int CNT_W = $clog2(wtv_pkg::LEVEL_W);

    logic [wtv_pkg::LEN_W-1:0]   rem_reg, rem_next;
    logic [wtv_pkg::LEVEL_W-1:0] quo_reg, quo_next;
    logic [wtv_pkg::LEN_W-1:0]   dsr_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;

    logic [wtv_pkg::LEN_W:0]     rem_shift;
    logic                        fits;

    // one shift and trial subtract
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[wtv_pkg::LEVEL_W-1]};
        fits      = (rem_shift >= {1'b0, dsr_reg});
        if (fits)
        begin
            rem_next = wtv_pkg::LEN_W'(rem_shift - {1'b0, dsr_reg});
        end
        else
        begin
            rem_next = rem_shift[wtv_pkg::LEN_W-1:0];
        end
        quo_next = {quo_reg[wtv_pkg::LEVEL_W-2:0], fits};
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(wtv_pkg::LEVEL_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // operands and partial results
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

// ===== sv/wavetable_voice_with_envelope_top.sv =====
// Sample tick: RD0, RD1, DIFF, MUL1, INTERP, MUL2, SCALE, MUL3, then OUT registers the result
// once the output is free. Note on / note off wait in S_DIV for the 32-step rate divider.
// Wave and tune writes stay in S_IDLE. One 16 x 32 multiplier is reused three times per tick.
// Reset (async, active low) restores config defaults, idles the envelope and zeroes phase;
// wave and tune tables keep their contents and need loading before use.
`timescale 1ns / 1ps

module wavetable_voice_with_envelope_top #(
    parameter int TABLE_BITS = 11,
    parameter int ACC_BITS   = 32,
    parameter int WAVE_COUNT = 4,
    parameter int NOTE_COUNT = 128
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [2:0]                          req_type,
    input  logic [6:0]                          note,
    input  logic [12:0]                         write_addr,
    input  logic [31:0]                         write_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [15:0]                  sample,
    output logic [2:0]                          env_phase,
    input  logic                                cfg_we,
    input  logic [wtv_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [wtv_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int FRAC_BITS  = ACC_BITS - TABLE_BITS;
    localparam int TABLE_SIZE = 1 << TABLE_BITS;
    localparam int STORE_SIZE = WAVE_COUNT * TABLE_SIZE;
    localparam int STORE_AW   = $clog2(STORE_SIZE);
    localparam int NOTE_AW    = (NOTE_COUNT > 1) ? $clog2(NOTE_COUNT) : 1;
    localparam int MUL_B_W    = (FRAC_BITS > 32) ? FRAC_BITS : 32;
    localparam int PROD_W     = 16 + MUL_B_W;
    localparam int SUM_W      = (ACC_BITS > 32) ? ACC_BITS : 32;

    localparam logic [PROD_W:0] FRAC_MASK_EXT =
        {{(PROD_W + 1 - FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RD0    = 4'd1;
    localparam logic [3:0] S_RD1    = 4'd2;
    localparam logic [3:0] S_DIFF   = 4'd3;
    localparam logic [3:0] S_MUL1   = 4'd4;
    localparam logic [3:0] S_INTERP = 4'd5;
    localparam logic [3:0] S_MUL2   = 4'd6;
    localparam logic [3:0] S_SCALE  = 4'd7;
    localparam logic [3:0] S_MUL3   = 4'd8;
    localparam logic [3:0] S_OUT    = 4'd9;
    localparam logic [3:0] S_DIV    = 4'd10;

    // control and voice state
    logic [3:0]                     state_reg, state_next;
    logic                           out_valid_reg, out_valid_next;
    logic [ACC_BITS-1:0]            phase_acc_reg, phase_acc_next;
    logic [31:0]                    phase_step_reg, phase_step_next;
    logic [2:0]                     env_state_reg, env_state_next;
    logic [wtv_pkg::LEVEL_W-1:0]    env_level_reg, env_level_next;
    logic [wtv_pkg::LEVEL_W-1:0]    env_rate_reg, env_rate_next;

    // configuration
    logic [1:0]                     wave_select_reg;
    logic [8:0]                     gain_q8_reg;
    logic [wtv_pkg::LEN_W-1:0]      attack_samples_reg;
    logic [wtv_pkg::LEN_W-1:0]      release_samples_reg;
    logic [wtv_pkg::LEVEL_W-1:0]    sustain_level_reg;

    // datapath registers
    logic [2:0]                     req_reg;
    logic [6:0]                     note_reg;
    logic [15:0]                    y0_reg;
    logic                           diff_neg_reg;
    logic                           s_neg_reg;
    logic [15:0]                    mul_a_reg;
    logic [MUL_B_W-1:0]             mul_b_reg;
    logic [PROD_W-1:0]              prod_reg;
    logic signed [15:0]             sample_reg;
    logic [2:0]                     env_phase_reg;

    // memories
    logic [15:0]                    wave_mem [STORE_SIZE];
    logic [31:0]                    tune_mem [NOTE_COUNT];
    logic [15:0]                    wave_rd_reg;
    logic [31:0]                    tune_rd_reg;

    // handshake and decode
    logic                           in_accept;
    logic                           out_free;
    logic                           note_ok;
    logic                           wave_we;
    logic                           tune_we;
    logic [31:0]                    wr_addr32;
    logic [31:0]                    note32;
    logic [31:0]                    note_reg32;
    logic [31:0]                    sel32;
    logic [31:0]                    rd_addr32;
    logic [TABLE_BITS-1:0]          idx0;
    logic [TABLE_BITS-1:0]          idx1;
    logic [STORE_AW-1:0]            wave_rd_addr;

    // divider hookup
    logic                           div_start;
    logic [wtv_pkg::LEVEL_W-1:0]    div_dividend;
    logic [wtv_pkg::LEN_W-1:0]      div_divisor;
    logic [wtv_pkg::LEN_W-1:0]      len_attack;
    logic [wtv_pkg::LEN_W-1:0]      len_release;
    wtv_pkg::div_stat_t             div_stat;
    logic [wtv_pkg::LEVEL_W-1:0]    div_quotient;

    // arithmetic intermediates
    logic [16:0]                    diff;
    logic [16:0]                    diff_abs;
    logic [PROD_W:0]                round_sum;
    logic [15:0]                    delta_mag;
    logic [16:0]                    delta;
    logic [16:0]                    interp;
    logic [16:0]                    interp_abs;
    logic [15:0]                    lvl_hi;
    logic [31:0]                    lvl_lo;
    logic [32:0]                    hl_sum;
    logic [15:0]                    scaled_mag;
    logic [15:0]                    gain_mag;
    logic [15:0]                    sat_word;
    logic [SUM_W-1:0]               phase_sum;
    logic [wtv_pkg::LEVEL_W-1:0]    headroom;
    logic [wtv_pkg::LEVEL_W-1:0]    above_sus;
    logic [2:0]                     step_state;
    logic [wtv_pkg::LEVEL_W-1:0]    step_level;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_accept = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;
    assign env_phase = env_phase_reg;

    // request decode
    assign wr_addr32  = 32'(write_addr);
    assign note32     = 32'(note);
    assign note_reg32 = 32'(note_reg);
    assign note_ok    = (note32 < 32'(NOTE_COUNT));
    assign wave_we    = in_accept && (req_type == wtv_pkg::REQ_WAVE_WR)
                        && (wr_addr32 < 32'(STORE_SIZE));
    assign tune_we    = in_accept && (req_type == wtv_pkg::REQ_TUNE_WR)
                        && (wr_addr32 < 32'(NOTE_COUNT));

    // wave table addressing, neighbor wraps inside the table
    assign sel32        = (32'(wave_select_reg) < 32'(WAVE_COUNT)) ? 32'(wave_select_reg) : 32'd0;
    assign idx0         = phase_acc_reg[ACC_BITS-1 -: TABLE_BITS];
    assign idx1         = idx0 + {{(TABLE_BITS-1){1'b0}}, 1'b1};
    assign rd_addr32    = (sel32 << TABLE_BITS)
                          | 32'((state_reg == S_RD0) ? idx0 : idx1);
    assign wave_rd_addr = rd_addr32[STORE_AW-1:0];

    // wave store
    always_ff @(posedge clk)
    begin
        if (wave_we)
        begin
            wave_mem[wr_addr32[STORE_AW-1:0]] <= write_data[15:0];
        end
        wave_rd_reg <= wave_mem[wave_rd_addr];
    end

    // tune table
    always_ff @(posedge clk)
    begin
        if (tune_we)
        begin
            tune_mem[wr_addr32[NOTE_AW-1:0]] <= write_data;
        end
        tune_rd_reg <= tune_mem[note_reg32[NOTE_AW-1:0]];
    end

    // rate divider operands
    assign len_attack   = (attack_samples_reg == '0) ? 24'd1 : attack_samples_reg;
    assign len_release  = (release_samples_reg == '0) ? 24'd1 : release_samples_reg;
    assign div_start    = in_accept
                          && (((req_type == wtv_pkg::REQ_NOTE_ON) && note_ok)
                          || ((req_type == wtv_pkg::REQ_NOTE_OFF)
                              && (env_state_reg != wtv_pkg::ENV_IDLE)));
    assign div_dividend = (req_type == wtv_pkg::REQ_NOTE_ON)
                          ? (wtv_pkg::LEVEL_MAX - env_level_reg) : env_level_reg;
    assign div_divisor  = (req_type == wtv_pkg::REQ_NOTE_ON) ? len_attack : len_release;

    wtv_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_quotient)
    );

    // shared multiplier
    always_ff @(posedge clk)
    begin
        prod_reg <= {{MUL_B_W{1'b0}}, mul_a_reg} * {16'd0, mul_b_reg};
    end

    // interpolation, level scaling and gain arithmetic
    always_comb
    begin
        diff      = {wave_rd_reg[15], wave_rd_reg} - {y0_reg[15], y0_reg};
        diff_abs  = diff[16] ? (17'd0 - diff) : diff;

        round_sum = {1'b0, prod_reg} + (diff_neg_reg ? FRAC_MASK_EXT : '0);
        delta_mag = round_sum[FRAC_BITS +: 16];
        delta     = diff_neg_reg ? (17'd0 - {1'b0, delta_mag}) : {1'b0, delta_mag};
        interp    = {y0_reg[15], y0_reg} + delta;
        interp_abs = interp[16] ? (17'd0 - interp) : interp;

        // divide by 2^32-1: high word plus one when high + low reaches the divisor
        lvl_hi     = prod_reg[47:32];
        lvl_lo     = prod_reg[31:0];
        hl_sum     = {1'b0, lvl_lo} + {17'd0, lvl_hi};
        scaled_mag = (hl_sum >= {1'b0, wtv_pkg::LEVEL_MAX}) ? (lvl_hi + 16'd1) : lvl_hi;

        // gain in q8, then clamp to the sample range
        gain_mag = prod_reg[23:8];
        if (s_neg_reg)
        begin
            sat_word = (gain_mag > 16'h8000) ? 16'h8000 : (16'd0 - gain_mag);
        end
        else
        begin
            sat_word = (gain_mag > 16'h7FFF) ? 16'h7FFF : gain_mag;
        end
    end

    // phase advance
    assign phase_sum = SUM_W'(phase_acc_reg) + SUM_W'(phase_step_reg);

    // envelope step taken with each tick
    always_comb
    begin
        headroom   = wtv_pkg::LEVEL_MAX - env_level_reg;
        above_sus  = env_level_reg - sustain_level_reg;
        step_state = env_state_reg;
        step_level = env_level_reg;
        case (env_state_reg)
            wtv_pkg::ENV_ATTACK:
            begin
                if (headroom <= env_rate_reg)
                begin
                    step_level = wtv_pkg::LEVEL_MAX;
                    step_state = wtv_pkg::ENV_DECAY;
                end
                else
                begin
                    step_level = env_level_reg + env_rate_reg;
                end
            end
            wtv_pkg::ENV_DECAY:
            begin
                if (env_level_reg <= sustain_level_reg)
                begin
                    step_state = wtv_pkg::ENV_SUSTAIN;
                end
                else if (above_sus <= env_rate_reg)
                begin
                    step_level = sustain_level_reg;
                    step_state = wtv_pkg::ENV_SUSTAIN;
                end
                else
                begin
                    step_level = env_level_reg - env_rate_reg;
                end
            end
            wtv_pkg::ENV_RELEASE:
            begin
                if (env_level_reg <= env_rate_reg)
                begin
                    step_level = '0;
                    step_state = wtv_pkg::ENV_IDLE;
                end
                else
                begin
                    step_level = env_level_reg - env_rate_reg;
                end
            end
            default:
            begin
                step_state = env_state_reg;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        phase_acc_next  = phase_acc_reg;
        phase_step_next = phase_step_reg;
        env_state_next  = env_state_reg;
        env_level_next  = env_level_reg;
        env_rate_next   = env_rate_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (req_type == wtv_pkg::REQ_TICK)
                    begin
                        state_next = S_RD0;
                    end
                    else if (div_start)
                    begin
                        state_next = S_DIV;
                    end
                end
            end
            S_RD0:    state_next = S_RD1;
            S_RD1:    state_next = S_DIFF;
            S_DIFF:   state_next = S_MUL1;
            S_MUL1:   state_next = S_INTERP;
            S_INTERP: state_next = S_MUL2;
            S_MUL2:   state_next = S_SCALE;
            S_SCALE:  state_next = S_MUL3;
            S_MUL3:   state_next = S_OUT;
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    phase_acc_next = phase_sum[ACC_BITS-1:0];
                    env_state_next = step_state;
                    env_level_next = step_level;
                    state_next     = S_IDLE;
                end
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    env_rate_next = div_quotient;
                    if (req_reg == wtv_pkg::REQ_NOTE_ON)
                    begin
                        phase_step_next = tune_rd_reg;
                        env_state_next  = wtv_pkg::ENV_ATTACK;
                    end
                    else
                    begin
                        env_state_next = wtv_pkg::ENV_RELEASE;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and voice state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= S_IDLE;
            out_valid_reg       <= 1'b0;
            phase_acc_reg       <= '0;
            phase_step_reg      <= '0;
            env_state_reg       <= wtv_pkg::ENV_IDLE;
            env_level_reg       <= '0;
            env_rate_reg        <= '0;
            wave_select_reg     <= 2'd0;
            gain_q8_reg         <= 9'd128;
            attack_samples_reg  <= 24'd44100;
            release_samples_reg <= 24'd44100;
            sustain_level_reg   <= 32'h7FFF_FFFF;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            phase_acc_reg  <= phase_acc_next;
            phase_step_reg <= phase_step_next;
            env_state_reg  <= env_state_next;
            env_level_reg  <= env_level_next;
            env_rate_reg   <= env_rate_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    wtv_pkg::CFG_WAVE_SELECT: wave_select_reg     <= cfg_data[1:0];
                    wtv_pkg::CFG_GAIN:        gain_q8_reg         <= cfg_data[8:0];
                    wtv_pkg::CFG_ATTACK:      attack_samples_reg  <= cfg_data[23:0];
                    wtv_pkg::CFG_RELEASE:     release_samples_reg <= cfg_data[23:0];
                    wtv_pkg::CFG_SUSTAIN:     sustain_level_reg   <= cfg_data;
                    default:
                    begin
                        sustain_level_reg <= sustain_level_reg;
                    end
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    req_reg  <= req_type;
                    note_reg <= note;
                end
            end
            S_RD1:
            begin
                y0_reg <= wave_rd_reg;
            end
            S_DIFF:
            begin
                diff_neg_reg <= diff[16];
                mul_a_reg    <= diff_abs[15:0];
                mul_b_reg    <= MUL_B_W'(phase_acc_reg[FRAC_BITS-1:0]);
            end
            S_INTERP:
            begin
                s_neg_reg <= interp[16];
                mul_a_reg <= interp_abs[15:0];
                mul_b_reg <= MUL_B_W'(env_level_reg);
            end
            S_SCALE:
            begin
                mul_a_reg <= scaled_mag;
                mul_b_reg <= MUL_B_W'(gain_q8_reg);
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    sample_reg    <= $signed(sat_word);
                    env_phase_reg <= step_state;
                end
            end
            default:
            begin
                mul_a_reg <= mul_a_reg;
            end
        endcase
    end

endmodule

// ===== sv/wtv_checker.sv =====
// port-level checks for the wavetable voice, bound to the top level
`timescale 1ns / 1ps
`include "wavetable_voice_with_envelope_top_macros.svh"

module wtv_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic [2:0]           req_type,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic signed [15:0]   sample,
    input logic [2:0]           env_phase
);

    // a stalled result word holds
    `WTV_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(sample) && $stable(env_phase), "result word changed while stalled")

    // a tick leaves the sequencer busy in the cycle after it is accepted
    `WTV_ASSERT_NEXT(a_tick_busy, in_valid && in_ready && (req_type == wtv_pkg::REQ_TICK), !in_ready, "ready right after a sample tick")

    // a wave write completes in its own cycle
    `WTV_ASSERT_NEXT(a_write_fast, in_valid && in_ready && (req_type == wtv_pkg::REQ_WAVE_WR), in_ready, "not ready after a wave write")

    // a new result appears together with a free input side
    `WTV_ASSERT_NOW(a_done_ready, $rose(out_valid), in_ready, "result shown while still busy")

endmodule

bind wavetable_voice_with_envelope_top wtv_checker u_wtv_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sample    (sample),
    .env_phase (env_phase)
);

// ===== test/wavetable_voice_with_envelope_top_tb.sv =====
// self-checking testbench for the wavetable voice with envelope, built around a cycle-free voice model
`timescale 1ns / 1ps

module wavetable_voice_with_envelope_top_tb;

    import wtv_pkg::*;

    // request codes the block must drop
    localparam logic [2:0] REQ_RSVD_5 = 3'd5;
    localparam logic [2:0] REQ_RSVD_6 = 3'd6;
    localparam logic [2:0] REQ_RSVD_7 = 3'd7;

    localparam int     WAVE_WORDS     = 8192;
    localparam int     NOTE_SLOTS     = 128;
    localparam int     FRAC_BITS      = 21;
    localparam longint FRAC_ONES      = 64'h1F_FFFF;
    localparam longint LEVEL_FULL     = 64'h0000_0000_FFFF_FFFF;
    localparam longint Q8_ONE         = 256;
    localparam longint SAMPLE_MAX     = 32767;
    localparam longint SAMPLE_MIN     = -32768;
    localparam int     CONFIG_SETTLE  = 40;
    localparam int     END_SETTLE     = 40;
    localparam int     HOLD_OFF_CYCLES = 400;
    localparam int     WATCHDOG_LIMIT = 4000;
    localparam int     SHOW_LIMIT     = 40;

    typedef struct packed {
        logic signed [15:0] smp;
        logic [2:0]         env;
    } voice_word_t;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    logic [2:0]              req_type;
    logic [6:0]              note;
    logic [12:0]             write_addr;
    logic [31:0]             write_data;
    logic                    out_valid;
    logic                    out_ready;
    logic signed [15:0]      sample;
    logic [2:0]              env_phase;
    logic                    cfg_we;
    logic [CFG_INDEX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;

    // voice model: settings, oscillator, envelope, tables
    bit [1:0]  sel_wave        = 2'd0;
    bit [8:0]  gain_setting    = 9'd128;
    bit [23:0] attack_len      = 24'd44100;
    bit [23:0] release_len     = 24'd44100;
    bit [31:0] sustain_setting = 32'h7FFF_FFFF;
    bit [31:0] voice_phase_acc = '0;
    bit [31:0] voice_phase_step = '0;
    bit [2:0]  env_state       = ENV_IDLE;
    bit [31:0] env_level       = '0;
    bit [31:0] env_rate        = '0;
    bit [15:0] wave_mem [WAVE_WORDS];
    bit [31:0] tune_mem [NOTE_SLOTS];

    voice_word_t expected_samples [$];
    voice_word_t want_word;

    int error_count = 0;
    int words_sent = 0;
    int quiet_cycles = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_cycles_left = 0;

    wavetable_voice_with_envelope_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .note       (note),
        .write_addr (write_addr),
        .write_data (write_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample     (sample),
        .env_phase  (env_phase),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // interpolated table value scaled by envelope level and gain
    function automatic logic signed [15:0] mix_sample();
        bit [12:0] entry;
        bit [12:0] next_entry;
        longint y0, y1, diff, mag, delta, interp, frac, level, gain, scaled, mixed;
        entry = {sel_wave, voice_phase_acc[31:FRAC_BITS]};
        next_entry = {sel_wave, voice_phase_acc[31:FRAC_BITS] + 11'd1};
        y0 = $signed(wave_mem[entry]);
        y1 = $signed(wave_mem[next_entry]);
        frac = voice_phase_acc[FRAC_BITS-1:0];
        diff = y1 - y0;
        mag = ((diff < 0) ? -diff : diff) * frac;
        // negative slope rounds toward minus infinity
        if (diff < 0)
            delta = -((mag + FRAC_ONES) >> FRAC_BITS);
        else
            delta = mag >> FRAC_BITS;
        interp = y0 + delta;
        level = env_level;
        gain = gain_setting;
        scaled = (interp * level) / LEVEL_FULL;
        mixed = (scaled * gain) / Q8_ONE;
        if (mixed > SAMPLE_MAX)
            mixed = SAMPLE_MAX;
        if (mixed < SAMPLE_MIN)
            mixed = SAMPLE_MIN;
        return mixed[15:0];
    endfunction

    // apply one accepted word to the voice model, queue the sample a tick produces
    function automatic void advance_voice(logic [2:0] rt, logic [6:0] nt, logic [12:0] wa,
                                          logic [31:0] wd);
        voice_word_t w;
        bit [31:0] len;
        case (rt)
            REQ_TICK:
            begin
                w.smp = mix_sample();
                voice_phase_acc += voice_phase_step;
                case (env_state)
                    ENV_ATTACK:
                    begin
                        if (LEVEL_MAX - env_level <= env_rate)
                        begin
                            env_level = LEVEL_MAX;
                            env_state = ENV_DECAY;
                        end
                        else
                            env_level += env_rate;
                    end
                    ENV_DECAY:
                    begin
                        if (env_level <= sustain_setting)
                            env_state = ENV_SUSTAIN;
                        else if (env_level - sustain_setting <= env_rate)
                        begin
                            env_level = sustain_setting;
                            env_state = ENV_SUSTAIN;
                        end
                        else
                            env_level -= env_rate;
                    end
                    ENV_RELEASE:
                    begin
                        if (env_level <= env_rate)
                        begin
                            env_level = '0;
                            env_state = ENV_IDLE;
                        end
                        else
                            env_level -= env_rate;
                    end
                    default: ;
                endcase
                w.env = env_state;
                expected_samples.push_back(w);
            end
            REQ_NOTE_ON:
            begin
                len = (attack_len == 0) ? 32'd1 : 32'(attack_len);
                voice_phase_step = tune_mem[nt];
                env_state = ENV_ATTACK;
                env_rate = (LEVEL_MAX - env_level) / len;
            end
            REQ_NOTE_OFF:
            begin
                len = (release_len == 0) ? 32'd1 : 32'(release_len);
                if (env_state != ENV_IDLE)
                begin
                    env_state = ENV_RELEASE;
                    env_rate = env_level / len;
                end
            end
            REQ_WAVE_WR: wave_mem[wa] = wd[15:0];
            REQ_TUNE_WR:
            begin
                if (wa < NOTE_SLOTS)
                    tune_mem[wa] = wd;
            end
            default: ;
        endcase
    endfunction

    // one line per mismatch, counted
    task automatic report_mismatch(input string what, input logic signed [31:0] got,
                                   input logic signed [31:0] want);
        error_count++;
        if (error_count <= SHOW_LIMIT)
            $display("mismatch on %s: got %0d, expected %0d at %0t ns", what, got, want, $time);
    endtask

    // offer one word, hold it until accepted, then update the model
    task automatic send_word(input logic [2:0] rt, input logic [6:0] nt, input logic [12:0] wa,
                             input logic [31:0] wd);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        req_type <= rt;
        note <= nt;
        write_addr <= wa;
        write_data <= wd;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        advance_voice(rt, nt, wa, wd);
        if (rt <= REQ_TUNE_WR)
            words_sent++;
        @(negedge clk);
    endtask

    task automatic send_tick();
        send_word(REQ_TICK, $urandom_range(127), $urandom_range(8191), $urandom);
    endtask

    // sender goes quiet until every expected sample is back
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (expected_samples.size() != 0);
    endtask

    // idle the block so no note event is still in its rate divider
    task automatic pause_for_config();
        wait_drained();
        repeat (CONFIG_SETTLE) @(negedge clk);
    endtask

    // write all five registers back to back
    task automatic write_settings(input bit [1:0] ws, input bit [8:0] gain, input bit [23:0] atk,
                                  input bit [23:0] rel, input bit [31:0] sus);
        logic [CFG_INDEX_W-1:0] regs [5] = '{CFG_WAVE_SELECT, CFG_GAIN, CFG_ATTACK,
                                            CFG_RELEASE, CFG_SUSTAIN};
        logic [CFG_DATA_W-1:0]  vals [5];
        vals[0] = 32'(ws);
        vals[1] = 32'(gain);
        vals[2] = 32'(atk);
        vals[3] = 32'(rel);
        vals[4] = sus;
        foreach (regs[i])
        begin
            cfg_we <= 1'b1;
            cfg_index <= regs[i];
            cfg_data <= vals[i];
            @(negedge clk);
        end
        cfg_we <= 1'b0;
        sel_wave = ws;
        gain_setting = gain;
        attack_len = atk;
        release_len = rel;
        sustain_setting = sus;
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 50; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 50; end
            default: begin send_idle_pct = 22; stall_pct = 22; end
        endcase
    endtask

    // fill every wave entry and every tune slot before anything reads them
    task automatic test_load_tables();
        bit [15:0] value;
        bit [31:0] tune;
        set_idling(0);
        for (int a = 0; a < WAVE_WORDS; a++)
        begin
            case ($urandom_range(7))
                0: value = 16'h7FFF;
                1: value = 16'h8000;
                default: value = $urandom_range(16'hFFFF);
            endcase
            send_word(REQ_WAVE_WR, $urandom_range(127), a, {16'($urandom), value});
        end
        for (int n = 0; n < NOTE_SLOTS; n++)
        begin
            if (n == 0)
                tune = '0;
            else if (n == NOTE_SLOTS - 1)
                tune = 32'hFFFF_FFFF;
            else if ($urandom_range(1))
                tune = $urandom;
            else
                tune = $urandom_range(32'h0010_0000);
            send_word(REQ_TUNE_WR, $urandom_range(127), n, tune);
        end
    endtask

    // corner cases of the envelope, dropped requests and table writes
    task automatic test_directed();
        // silent idle voice, dropped codes, note off while idle
        send_tick();
        send_word(REQ_RSVD_5, 7'h7F, 13'h1FFF, 32'hFFFF_FFFF);
        send_word(REQ_RSVD_6, 7'h00, 13'h0000, 32'h0000_0000);
        send_word(REQ_RSVD_7, 7'h55, 13'h0AAA, 32'hA5A5_A5A5);
        send_word(REQ_NOTE_OFF, 7'd0, 13'd0, 32'd0);
        send_tick();
        // tune writes past the last note are dropped
        send_word(REQ_TUNE_WR, 7'd0, 13'd128, 32'hFFFF_FFFF);
        send_word(REQ_TUNE_WR, 7'd0, 13'h1FFF, 32'h0000_0000);
        // extreme wave entries at both ends of the store
        send_word(REQ_WAVE_WR, 7'd0, 13'd0, 32'hFFFF_7FFF);
        send_word(REQ_WAVE_WR, 7'h7F, 13'h1FFF, 32'h0000_8000);
        send_word(REQ_TUNE_WR, 7'd0, 13'd127, 32'hFFFF_FFFF);
        send_word(REQ_NOTE_ON, 7'd0, 13'd0, 32'd0);
        send_tick();
        send_tick();

        // one-sample attack and release, sustain at full scale, gain saturating
        pause_for_config();
        write_settings(2'd3, 9'd511, 24'd0, 24'd0, 32'hFFFF_FFFF);
        send_word(REQ_NOTE_ON, 7'd127, 13'd0, 32'd0);
        send_tick();
        send_tick();
        // note on at full level gives zero headroom
        send_word(REQ_NOTE_ON, 7'd127, 13'd0, 32'd0);
        send_tick();
        send_tick();
        send_word(REQ_NOTE_OFF, 7'd0, 13'd0, 32'd0);
        send_tick();

        // longest lengths, release rate rounds to zero and the level holds
        pause_for_config();
        write_settings(2'd2, 9'd256, 24'hFF_FFFF, 24'hFF_FFFF, 32'd0);
        send_word(REQ_NOTE_ON, 7'd5, 13'd0, 32'd0);
        send_tick();
        send_word(REQ_NOTE_OFF, 7'd0, 13'd0, 32'd0);
        send_tick();
        send_tick();
    endtask

    // random notes under changing settings and idling patterns
    task automatic test_random_voice();
        int goal;
        bit [23:0] lens [2];
        for (int blk = 0; blk < 8; blk++)
        begin
            pause_for_config();
            set_idling(blk % 4);
            foreach (lens[i])
            begin
                case ($urandom_range(9))
                    0: lens[i] = '0;
                    1: lens[i] = 24'hFF_FFFF;
                    2: lens[i] = $urandom_range(24'hFF_FFFF);
                    default: lens[i] = $urandom_range(48, 1);
                endcase
            end
            case (blk)
                0: write_settings(2'd0, 9'd256, 24'd1, 24'd1, 32'd0);
                1: write_settings(2'd3, 9'd0, lens[0], lens[1], 32'hFFFF_FFFF);
                default:
                    write_settings($urandom_range(3),
                                   $urandom_range(1) ? 9'($urandom_range(511)) : 9'd256,
                                   lens[0], lens[1],
                                   $urandom_range(1) ? $urandom : 32'h7FFF_FFFF);
            endcase
            goal = words_sent + 160;
            while (words_sent < goal)
            begin
                if ($urandom_range(9) < 7)
                begin
                    // a whole note: on, ticks, mostly off and more ticks
                    send_word(REQ_NOTE_ON, $urandom_range(127), $urandom_range(8191), $urandom);
                    repeat ($urandom_range(60, 1)) send_tick();
                    if ($urandom_range(3) != 0)
                    begin
                        send_word(REQ_NOTE_OFF, $urandom_range(127), $urandom_range(8191),
                                  $urandom);
                        repeat ($urandom_range(70, 1)) send_tick();
                    end
                end
                else
                begin
                    // stray words between notes
                    case ($urandom_range(3))
                        0: send_word(REQ_WAVE_WR, $urandom_range(127), $urandom_range(8191),
                                     $urandom);
                        1: send_word(REQ_TUNE_WR, $urandom_range(127),
                                     $urandom_range(1) ? $urandom_range(127)
                                                       : $urandom_range(8191),
                                     $urandom);
                        2: send_word(REQ_RSVD_5 + $urandom_range(2), $urandom_range(127),
                                     $urandom_range(8191), $urandom);
                        default: send_word(REQ_NOTE_OFF, $urandom_range(127),
                                           $urandom_range(8191), $urandom);
                    endcase
                end
            end
        end
    endtask

    // long receiver hold-off fills the pipe, then the sender waits for a full drain
    task automatic test_backpressure();
        pause_for_config();
        set_idling(0);
        write_settings(2'd1, 9'd256, 24'd32, 24'd32, 32'h8000_0000);
        send_word(REQ_NOTE_ON, $urandom_range(127), 13'd0, 32'd0);
        hold_cycles_left = HOLD_OFF_CYCLES;
        repeat (40) send_tick();
        wait_drained();
        repeat (20) send_tick();
        send_word(REQ_NOTE_OFF, 7'd0, 13'd0, 32'd0);
        repeat (40) send_tick();
    endtask

    // receiver: random stalls, or a counted hold-off when asked
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles_left > 0)
            begin
                out_ready <= 1'b0;
                hold_cycles_left--;
            end
            else
                out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // compare each accepted result word with the oldest expected sample
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            if (expected_samples.size() == 0)
                report_mismatch("unexpected result word", sample, 0);
            else
            begin
                want_word = expected_samples.pop_front();
                if (sample !== want_word.smp)
                    report_mismatch("sample", sample, want_word.smp);
                if (env_phase !== want_word.env)
                    report_mismatch("env_phase", env_phase, want_word.env);
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge clk)
    begin
        if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[wavetable_voice_with_envelope_top] ERROR");
            $finish;
        end
    end

    // reset, test sequence, final verdict
    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        req_type = REQ_TICK;
        note = '0;
        write_addr = '0;
        write_data = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_WAVE_SELECT;
        cfg_data = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_load_tables();
        test_directed();
        test_random_voice();
        test_backpressure();

        wait_drained();
        repeat (END_SETTLE) @(negedge clk);
        if (error_count == 0 && expected_samples.size() == 0)
            $display("[wavetable_voice_with_envelope_top] OK");
        else
            $display("[wavetable_voice_with_envelope_top] ERROR");
        $finish;
    end

endmodule
